// ===== hdl/bakf_pkg.sv =====
// ----------------------------------------------------------------------------
// bakf_pkg
// Shared types, codes and micro-program for the altitude Kalman filter.
// ----------------------------------------------------------------------------
package bakf_pkg;

  localparam int VW = 32;   // datapath value width
  localparam int FB = 20;   // fraction bits
  localparam int CW = 31;   // configuration register width
  localparam int QW = 52;   // quotient bits produced by the divider

  typedef logic signed [VW-1:0] val_t;

  // input actions
  localparam logic [1:0] ACT_PREDICT = 2'd0;
  localparam logic [1:0] ACT_BARO    = 2'd1;
  localparam logic [1:0] ACT_ACCEL   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_QP    = 3'd0;
  localparam logic [2:0] REG_QV    = 3'd1;
  localparam logic [2:0] REG_QA    = 3'd2;
  localparam logic [2:0] REG_QB    = 3'd3;
  localparam logic [2:0] REG_RB    = 3'd4;
  localparam logic [2:0] REG_RA    = 3'd5;
  localparam logic [2:0] REG_PINIT = 3'd6;

  // ALU operations
  localparam logic [2:0] OP_LD  = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  // external load sources
  localparam logic [3:0] EXT_ZERO  = 4'd0;
  localparam logic [3:0] EXT_DT    = 4'd1;
  localparam logic [3:0] EXT_Z     = 4'd2;
  localparam logic [3:0] EXT_QP    = 4'd3;
  localparam logic [3:0] EXT_QV    = 4'd4;
  localparam logic [3:0] EXT_QA    = 4'd5;
  localparam logic [3:0] EXT_QB    = 4'd6;
  localparam logic [3:0] EXT_RB    = 4'd7;
  localparam logic [3:0] EXT_RA    = 4'd8;
  localparam logic [3:0] EXT_PINIT = 4'd9;

  // working memory map
  localparam logic [4:0] A_X0  = 5'd0;
  localparam logic [4:0] A_P0  = 5'd4;
  localparam logic [4:0] A_PL  = 5'd19;  // last covariance entry
  localparam logic [4:0] A_K0  = 5'd20;
  localparam logic [4:0] A_KS0 = 5'd24;
  localparam logic [4:0] A_T0  = 5'd28;  // dt
  localparam logic [4:0] A_T1  = 5'd29;  // innovation
  localparam logic [4:0] A_T2  = 5'd30;  // S
  localparam logic [4:0] A_T3  = 5'd31;  // scratch

  // program phases
  localparam logic [2:0] PH_PLD  = 3'd0;
  localparam logic [2:0] PH_PTR  = 3'd1;
  localparam logic [2:0] PH_PQ   = 3'd2;
  localparam logic [2:0] PH_UPRE = 3'd3;
  localparam logic [2:0] PH_UGN  = 3'd4;
  localparam logic [2:0] PH_UCOR = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] time_step;
    val_t        measurement;
  } in_item_t;

  typedef struct packed {
    val_t position;
    val_t velocity;
    val_t acceleration;
    val_t accel_bias;
    logic update_skipped;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [4:0] srca;
    logic [4:0] srcb;
    logic [3:0] ext;
  } uop_t;

  typedef struct packed {
    logic rd;
    logic wb;
    logic mul;
    logic div_start;
    logic cap_in;
    logic load_out;
    logic skip;
    uop_t u;
  } dp_cmd_t;

  typedef struct packed {
    logic res_zero;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [CW-1:0] qp;
    logic [CW-1:0] qv;
    logic [CW-1:0] qa;
    logic [CW-1:0] qb;
    logic [CW-1:0] rb;
    logic [CW-1:0] ra;
    logic [CW-1:0] pinit;
  } cfg_regs_t;

  function automatic uop_t mk_uop(logic [2:0] op, logic [4:0] dst, logic [4:0] sa,
                                  logic [4:0] sb, logic [3:0] ext);
    uop_t u;
    u.op   = op;
    u.dst  = dst;
    u.srca = sa;
    u.srcb = sb;
    u.ext  = ext;
    return u;
  endfunction

  // Micro-program: one operation per (phase, outer index i, step s).
  // hsel picks the observed state: 0 altitude, 1 acceleration.
  function automatic uop_t prog_uop(logic [2:0] ph, logic hsel, logic [3:0] i,
                                    logic [3:0] s);
    uop_t       u;
    logic [4:0] h;
    logic [4:0] ii;
    logic [4:0] jj;
    logic [4:0] base;
    logic [4:0] stride;
    logic [4:0] w0, w1, w2, w3;
    logic [4:0] pd;
    logic [3:0] sm2;
    logic [3:0] im5;
    h   = hsel ? 5'd2 : 5'd0;
    ii  = {3'b0, i[1:0]};
    sm2 = s - 4'd2;
    jj  = {3'b0, sm2[2:1]};
    im5 = i - 4'd5;
    // transition t=0 on the estimate, t=1..4 on columns, t=5..8 on rows
    if (i == 4'd0) begin
      base   = A_X0;
      stride = 5'd1;
    end else if (i < 4'd5) begin
      base   = A_P0 + {1'b0, i} - 5'd1;
      stride = 5'd4;
    end else begin
      base   = A_P0 + {1'b0, im5[1:0], 2'b00};
      stride = 5'd1;
    end
    w0 = base;
    w1 = base + stride;
    w2 = base + {stride[3:0], 1'b0};
    w3 = base + stride + {stride[3:0], 1'b0};
    pd = A_P0 + ii * 5'd5;
    u  = mk_uop(OP_LD, A_T3, A_T3, A_T3, EXT_ZERO);
    case (ph)
      PH_PLD: u = mk_uop(OP_LD, A_T0, A_T0, A_T0, EXT_DT);
      PH_PTR: begin
        case (s)
          4'd0:    u = mk_uop(OP_MUL, A_T3, A_T0, w1, EXT_ZERO);
          4'd1:    u = mk_uop(OP_ADD, w0, w0, A_T3, EXT_ZERO);
          4'd2:    u = mk_uop(OP_SUB, A_T3, w2, w3, EXT_ZERO);
          4'd3:    u = mk_uop(OP_MUL, A_T3, A_T0, A_T3, EXT_ZERO);
          default: u = mk_uop(OP_ADD, w1, w1, A_T3, EXT_ZERO);
        endcase
      end
      PH_PQ: begin
        if (!s[0]) u = mk_uop(OP_LD, A_T3, A_T3, A_T3, EXT_QP + {2'b0, i[1:0]});
        else       u = mk_uop(OP_ADD, pd, pd, A_T3, EXT_ZERO);
      end
      PH_UPRE: begin
        case (s)
          4'd0:    u = mk_uop(OP_LD, A_T1, A_T1, A_T1, EXT_Z);
          4'd1:    u = mk_uop(OP_SUB, A_T1, A_T1, A_X0 + h, EXT_ZERO);
          4'd2:    u = mk_uop(OP_LD, A_T2, A_T2, A_T2, hsel ? EXT_RA : EXT_RB);
          default: u = mk_uop(OP_ADD, A_T2, A_P0 + h * 5'd5, A_T2, EXT_ZERO);
        endcase
      end
      PH_UGN: begin
        if (!s[0]) u = mk_uop(OP_DIV, A_K0 + ii, A_P0 + {ii[2:0], 2'b00} + h, A_T2,
                              EXT_ZERO);
        else       u = mk_uop(OP_MUL, A_KS0 + ii, A_K0 + ii, A_T2, EXT_ZERO);
      end
      PH_UCOR: begin
        if (s == 4'd0)      u = mk_uop(OP_MUL, A_T3, A_K0 + ii, A_T1, EXT_ZERO);
        else if (s == 4'd1) u = mk_uop(OP_ADD, A_X0 + ii, A_X0 + ii, A_T3, EXT_ZERO);
        else if (!s[0])     u = mk_uop(OP_MUL, A_T3, A_KS0 + ii, A_K0 + jj, EXT_ZERO);
        else u = mk_uop(OP_SUB, A_P0 + {ii[2:0], 2'b00} + jj,
                        A_P0 + {ii[2:0], 2'b00} + jj, A_T3, EXT_ZERO);
      end
      default: u = mk_uop(OP_LD, A_T3, A_T3, A_T3, EXT_ZERO);
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/baro_accel_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// baro_accel_kalman_filter
// Four-state altitude Kalman filter (altitude, velocity, acceleration, bias).
// ----------------------------------------------------------------------------
// One item is in work at a time; a sequencer runs it as micro-operations on a
// single shared saturating ALU over a 32-entry working memory (each operation
// passes FETCH and EXEC; a multiply adds MWB, a divide waits in DIVW). An update's
// time is set mostly by the one-bit-per-cycle divider (one division per gain
// term, four terms); a skipped update stops once S is found to be zero. The next
// item is taken while the previous result waits in the output register. After
// reset a clearing pass loads the estimates and covariance before the first item
// is taken; a p_initial write starts a pass that reloads the covariance.
module baro_accel_kalman_filter import bakf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_regs_t cfg;
  logic      pinit_wr;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  bakf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .pinit_wr (pinit_wr)
  );

  bakf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pinit_wr  (pinit_wr),
    .stat      (stat),
    .cmd       (cmd)
  );

  bakf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== hdl/bakf_regs.sv =====
// ----------------------------------------------------------------------------
// bakf_regs
// APB configuration registers: noise variances and initial covariance.
// ----------------------------------------------------------------------------
module bakf_regs import bakf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   cfg,
  output logic        pinit_wr
);

  cfg_regs_t  cfg_r;
  logic       wr;
  logic [2:0] idx;

  assign idx      = paddr[4:2];
  assign wr       = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign pinit_wr = wr && (idx == REG_PINIT);
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qp    <= 31'd1049;
      cfg_r.qv    <= 31'd10486;
      cfg_r.qa    <= 31'd104858;
      cfg_r.qb    <= 31'd0;
      cfg_r.rb    <= 31'd377487;
      cfg_r.ra    <= 31'd1049;
      cfg_r.pinit <= 31'd2097152;
    end else if (wr) begin
      unique case (idx)
        REG_QP:    cfg_r.qp    <= pwdata[CW-1:0];
        REG_QV:    cfg_r.qv    <= pwdata[CW-1:0];
        REG_QA:    cfg_r.qa    <= pwdata[CW-1:0];
        REG_QB:    cfg_r.qb    <= pwdata[CW-1:0];
        REG_RB:    cfg_r.rb    <= pwdata[CW-1:0];
        REG_RA:    cfg_r.ra    <= pwdata[CW-1:0];
        REG_PINIT: cfg_r.pinit <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QP:    prdata = {1'b0, cfg_r.qp};
      REG_QV:    prdata = {1'b0, cfg_r.qv};
      REG_QA:    prdata = {1'b0, cfg_r.qa};
      REG_QB:    prdata = {1'b0, cfg_r.qb};
      REG_RB:    prdata = {1'b0, cfg_r.rb};
      REG_RA:    prdata = {1'b0, cfg_r.ra};
      REG_PINIT: prdata = {1'b0, cfg_r.pinit};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/bakf_dp.sv =====
// ----------------------------------------------------------------------------
// bakf_dp
// Datapath: working memory, saturating ALU, multiplier, serial divider.
// ----------------------------------------------------------------------------
module bakf_dp import bakf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  input  cfg_regs_t cfg,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  val_t        mem [32];
  val_t        rda_r, rdb_r;
  val_t        xs_r [4];
  logic [30:0] dt_r;
  val_t        z_r;
  out_item_t   out_r;

  logic [63:0] prod_r;
  logic        pneg_r;

  logic [QW-1:0] dnum_r, dquo_r;
  logic [31:0]   drem_r, dy_r;
  logic          dneg_r, dyz_r, dbusy_r;
  logic [5:0]    dcnt_r;

  logic [31:0] ma, mb;
  logic [32:0] rem2;
  logic        dge;
  logic        rround;
  logic [QW:0] qmag;
  logic [63:0] prnd;
  logic [32:0] sum33, dif33;
  val_t        ext_v, wb_v;

  function automatic logic [31:0] mag_of(val_t v);
    return v[VW-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic val_t from_sm(logic neg, logic [QW:0] mag);
    if (neg) begin
      if (mag > {21'd0, 32'h8000_0000}) return 32'sh8000_0000;
      return val_t'(~mag[31:0] + 32'd1);
    end
    if (mag > {21'd0, 32'h7FFF_FFFF}) return 32'sh7FFF_FFFF;
    return val_t'(mag[31:0]);
  endfunction

  function automatic val_t sat33(logic [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return val_t'(v[31:0]);
  endfunction

  assign ma    = mag_of(rda_r);
  assign mb    = mag_of(rdb_r);
  assign sum33 = {rda_r[31], rda_r} + {rdb_r[31], rdb_r};
  assign dif33 = {rda_r[31], rda_r} - {rdb_r[31], rdb_r};
  assign prnd  = prod_r + (64'd1 << (FB - 1));

  // restoring divide step on {rem, next numerator bit}
  assign rem2   = {drem_r, dnum_r[QW-1]};
  assign dge    = rem2 >= {1'b0, dy_r};
  assign rround = drem_r >= (dy_r - drem_r);
  assign qmag   = {1'b0, dquo_r} + {{QW{1'b0}}, rround};

  always_comb begin
    case (cmd.u.ext)
      EXT_DT:    ext_v = val_t'({1'b0, dt_r});
      EXT_Z:     ext_v = z_r;
      EXT_QP:    ext_v = val_t'({1'b0, cfg.qp});
      EXT_QV:    ext_v = val_t'({1'b0, cfg.qv});
      EXT_QA:    ext_v = val_t'({1'b0, cfg.qa});
      EXT_QB:    ext_v = val_t'({1'b0, cfg.qb});
      EXT_RB:    ext_v = val_t'({1'b0, cfg.rb});
      EXT_RA:    ext_v = val_t'({1'b0, cfg.ra});
      EXT_PINIT: ext_v = val_t'({1'b0, cfg.pinit});
      default:   ext_v = '0;
    endcase
  end

  always_comb begin
    case (cmd.u.op)
      OP_ADD:  wb_v = sat33(sum33);
      OP_SUB:  wb_v = sat33(dif33);
      OP_MUL:  wb_v = from_sm(pneg_r, {9'd0, prnd[63:FB]});
      OP_DIV:  wb_v = dyz_r ? '0 : from_sm(dneg_r, qmag);
      default: wb_v = ext_v;
    endcase
  end

  assign stat.res_zero = (wb_v == '0);
  assign stat.div_done = !dbusy_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (cmd.wb) mem[cmd.u.dst] <= wb_v;
    if (cmd.rd) begin
      rda_r <= mem[cmd.u.srca];
      rdb_r <= mem[cmd.u.srcb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb && (cmd.u.dst[4:2] == A_X0[4:2])) xs_r[cmd.u.dst[1:0]] <= wb_v;
    if (cmd.cap_in) begin
      dt_r <= in_data.time_step;
      z_r  <= in_data.measurement;
    end
    if (cmd.mul) begin
      prod_r <= 64'(ma) * 64'(mb);
      pneg_r <= rda_r[VW-1] ^ rdb_r[VW-1];
    end
    if (cmd.load_out) begin
      out_r.position       <= xs_r[0];
      out_r.velocity       <= xs_r[1];
      out_r.acceleration   <= xs_r[2];
      out_r.accel_bias     <= xs_r[3];
      out_r.update_skipped <= cmd.skip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && (dcnt_r == 6'(QW - 1))) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum_r <= {ma, {FB{1'b0}}};
      dquo_r <= '0;
      drem_r <= '0;
      dy_r   <= mb;
      dyz_r  <= (mb == 32'd0);
      dneg_r <= rda_r[VW-1] ^ rdb_r[VW-1];
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dnum_r <= {dnum_r[QW-2:0], 1'b0};
      dquo_r <= {dquo_r[QW-2:0], dge};
      drem_r <= dge ? 32'(rem2 - {1'b0, dy_r}) : rem2[31:0];
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

endmodule

// ===== hdl/bakf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bakf_ctrl
// Sequencer: walks the micro-program and drives the datapath.
// ----------------------------------------------------------------------------
module bakf_ctrl import bakf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       pinit_wr,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_MWB   = 3'd4;
  localparam logic [2:0] ST_DIVW  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [3:0] i_r, i_nxt;
  logic [3:0] s_r, s_nxt;
  logic       hsel_r, hsel_nxt;
  logic       skip_r, skip_nxt;
  logic [4:0] swc_r, swc_nxt;
  logic       ov_r, ov_nxt;

  uop_t       u;
  logic [3:0] s_last, i_last;
  logic [2:0] adv_state, adv_ph;
  logic [3:0] adv_i, adv_s;
  logic       sw_diag;

  assign u         = prog_uop(ph_r, hsel_r, i_r, s_r);
  assign out_valid = ov_r;
  assign sw_diag   = (swc_r == A_P0) || (swc_r == 5'd9) || (swc_r == 5'd14) ||
                     (swc_r == A_PL);

  always_comb begin
    case (ph_r)
      PH_PTR:  begin s_last = 4'd4; i_last = 4'd8; end
      PH_PQ:   begin s_last = 4'd1; i_last = 4'd3; end
      PH_UPRE: begin s_last = 4'd3; i_last = 4'd0; end
      PH_UGN:  begin s_last = 4'd1; i_last = 4'd3; end
      PH_UCOR: begin s_last = 4'd9; i_last = 4'd3; end
      default: begin s_last = 4'd0; i_last = 4'd0; end
    endcase
  end

  // position after the current operation retires
  always_comb begin
    adv_state = ST_FETCH;
    adv_ph    = ph_r;
    adv_i     = i_r;
    adv_s     = s_r + 4'd1;
    if (s_r == s_last) begin
      adv_s = '0;
      adv_i = i_r + 4'd1;
      if (i_r == i_last) begin
        adv_i  = '0;
        adv_ph = ph_r + 3'd1;
        if ((ph_r == PH_PQ) || (ph_r == PH_UCOR)) adv_state = ST_DONE;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    hsel_nxt  = hsel_r;
    skip_nxt  = skip_r;
    swc_nxt   = swc_r;
    ov_nxt    = ov_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.u     = u;
    cmd.skip  = skip_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // clearing pass: estimates (after reset only) and covariance
        cmd.u  = mk_uop(OP_LD, swc_r, swc_r, swc_r, sw_diag ? EXT_PINIT : EXT_ZERO);
        cmd.wb = 1'b1;
        if (pinit_wr && (swc_r >= A_P0)) swc_nxt = A_P0;
        else if (swc_r == A_PL) state_nxt = ST_IDLE;
        else swc_nxt = swc_r + 5'd1;
      end
      ST_IDLE: begin
        in_ready = !pinit_wr;
        if (pinit_wr) begin
          swc_nxt   = A_P0;
          state_nxt = ST_INIT;
        end else if (in_valid) begin
          cmd.cap_in = 1'b1;
          hsel_nxt   = (in_action == ACT_ACCEL);
          skip_nxt   = 1'b0;
          i_nxt      = '0;
          s_nxt      = '0;
          case (in_action)
            ACT_PREDICT: begin ph_nxt = PH_PLD;  state_nxt = ST_FETCH; end
            ACT_BARO,
            ACT_ACCEL:   begin ph_nxt = PH_UPRE; state_nxt = ST_FETCH; end
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (u.op == OP_MUL) begin
          cmd.mul   = 1'b1;
          state_nxt = ST_MWB;
        end else if (u.op == OP_DIV) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVW;
        end else begin
          cmd.wb = 1'b1;
          if ((ph_r == PH_UPRE) && (s_r == s_last) && stat.res_zero) begin
            skip_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = adv_state;
            ph_nxt    = adv_ph;
            i_nxt     = adv_i;
            s_nxt     = adv_s;
          end
        end
      end
      ST_MWB: begin
        cmd.wb    = 1'b1;
        state_nxt = adv_state;
        ph_nxt    = adv_ph;
        i_nxt     = adv_i;
        s_nxt     = adv_s;
      end
      ST_DIVW: begin
        if (stat.div_done) begin
          cmd.wb    = 1'b1;
          state_nxt = adv_state;
          ph_nxt    = adv_ph;
          i_nxt     = adv_i;
          s_nxt     = adv_s;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      swc_r   <= A_X0;
      ov_r    <= 1'b0;
      ph_r    <= PH_PLD;
      i_r     <= '0;
      s_r     <= '0;
      hsel_r  <= 1'b0;
      skip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      swc_r   <= swc_nxt;
      ov_r    <= ov_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
      hsel_r  <= hsel_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// ===== tb/sv/baro_accel_kalman_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_accel_kalman_filter_test
// Drives predict and update actions through the filter under several noise
// settings and checks every estimate against a fixed-point filter model.
// ----------------------------------------------------------------------------
module baro_accel_kalman_filter_test;
  import bakf_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  baro_accel_kalman_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // filter model state
  longint    est[4];
  longint    cov[16];
  longint    noise[7];
  in_item_t  pending_items[$];
  out_item_t expected_estimates[$];
  bit        failed;
  bit        quiet;
  int        hold_cycles;
  int        in_gap;
  int        out_gap;
  bit        in_ready_seen;
  out_item_t want;

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] x, y, q;
    x = (a < 0) ? -a : a;
    y = (b < 0) ? -b : b;
    q = (x * y + 64'd524288) >> FB;
    return sat(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint fx_div(longint n, longint d);
    logic [63:0] x, y, q, r;
    x = (n < 0) ? -n : n;
    y = (d < 0) ? -d : d;
    if (y == 0) return 0;
    q = (x << FB) / y;
    r = (x << FB) % y;
    if (r >= y - r) q = q + 1;
    return sat(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic void reload_cov();
    for (int i = 0; i < 16; i++) cov[i] = (i % 5 == 0) ? noise[REG_PINIT] : 0;
  endfunction

  // x0 += dt*x1; x1 += dt*(x2-x3) over four entries of the state or covariance
  function automatic void advance(int i0, int i1, int i2, int i3, bit on_cov, longint dt);
    longint w0, w1, w2, w3;
    w0 = on_cov ? cov[i0] : est[i0];
    w1 = on_cov ? cov[i1] : est[i1];
    w2 = on_cov ? cov[i2] : est[i2];
    w3 = on_cov ? cov[i3] : est[i3];
    w0 = sat(w0 + fx_mul(dt, w1));
    w1 = sat(w1 + fx_mul(dt, sat(w2 - w3)));
    if (on_cov) begin
      cov[i0] = w0;
      cov[i1] = w1;
    end else begin
      est[i0] = w0;
      est[i1] = w1;
    end
  endfunction

  function automatic bit correct(int h, longint z, longint r);
    longint k[4], ks[4];
    longint innov, s;
    innov = sat(z - est[h]);
    s = sat(cov[5 * h] + r);
    if (s == 0) return 1;
    for (int i = 0; i < 4; i++) begin
      k[i] = fx_div(cov[4 * i + h], s);
      ks[i] = fx_mul(k[i], s);
    end
    for (int i = 0; i < 4; i++) begin
      est[i] = sat(est[i] + fx_mul(k[i], innov));
      for (int j = 0; j < 4; j++)
        cov[4 * i + j] = sat(cov[4 * i + j] - fx_mul(ks[i], k[j]));
    end
    return 0;
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    out_item_t o;
    longint    dt, z;
    bit        skipped;
    dt = longint'(it.time_step);
    z = longint'(it.measurement);
    skipped = 0;
    case (it.action)
      ACT_PREDICT: begin
        advance(0, 1, 2, 3, 0, dt);
        for (int j = 0; j < 4; j++) advance(j, 4 + j, 8 + j, 12 + j, 1, dt);
        for (int j = 0; j < 4; j++) advance(4 * j, 4 * j + 1, 4 * j + 2, 4 * j + 3, 1, dt);
        cov[0] = sat(cov[0] + noise[REG_QP]);
        cov[5] = sat(cov[5] + noise[REG_QV]);
        cov[10] = sat(cov[10] + noise[REG_QA]);
        cov[15] = sat(cov[15] + noise[REG_QB]);
      end
      ACT_BARO:  skipped = correct(0, z, noise[REG_RB]);
      ACT_ACCEL: skipped = correct(2, z, noise[REG_RA]);
      default: ;
    endcase
    o.position = est[0][31:0];
    o.velocity = est[1][31:0];
    o.acceleration = est[2][31:0];
    o.accel_bias = est[3][31:0];
    o.update_skipped = skipped;
    return o;
  endfunction

  function automatic void push_item(logic [1:0] act, logic [30:0] dt, logic [31:0] z);
    in_item_t it;
    it.action = act;
    it.time_step = dt;
    it.measurement = z;
    pending_items.push_back(it);
  endfunction

  function automatic void push_random(int n);
    logic [1:0]  act;
    logic [30:0] dt;
    logic [31:0] z;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) act = ACT_PREDICT;
      else if (pick < 68) act = ACT_BARO;
      else if (pick < 95) act = ACT_ACCEL;
      else act = 2'd3;
      dt = 31'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 131072));
      if ($urandom_range(0, 9) == 0) z = $urandom;
      else z = $urandom_range(0, 1 << 26) - (1 << 25);
      push_item(act, dt, z);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    noise[idx] = longint'(value[30:0]);
    if (idx == REG_PINIT) reload_cov();
  endtask

  // sampled at the rising edge, where the last transfer still shows in_valid
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_estimates.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready_seen) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_valid <= 0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(0, 4);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_ready_seen = in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_estimates.push_back(filter_step(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1;
      end else begin
        want = expected_estimates.pop_front();
        if (out_data.position !== want.position) begin
          $display("%0t: position exp %h got %h", $time, want.position, out_data.position);
          failed = 1;
        end
        if (out_data.velocity !== want.velocity) begin
          $display("%0t: velocity exp %h got %h", $time, want.velocity, out_data.velocity);
          failed = 1;
        end
        if (out_data.acceleration !== want.acceleration) begin
          $display("%0t: acceleration exp %h got %h", $time, want.acceleration,
                   out_data.acceleration);
          failed = 1;
        end
        if (out_data.accel_bias !== want.accel_bias) begin
          $display("%0t: accel_bias exp %h got %h", $time, want.accel_bias,
                   out_data.accel_bias);
          failed = 1;
        end
        if (out_data.update_skipped !== want.update_skipped) begin
          $display("%0t: update_skipped exp %b got %b", $time, want.update_skipped,
                   out_data.update_skipped);
          failed = 1;
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    failed = 0;
    quiet = 0;
    hold_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    in_ready_seen = 0;
    noise[REG_QP] = 1049;
    noise[REG_QV] = 10486;
    noise[REG_QA] = 104858;
    noise[REG_QB] = 0;
    noise[REG_RB] = 377487;
    noise[REG_RA] = 1049;
    noise[REG_PINIT] = 2097152;
    for (int i = 0; i < 4; i++) est[i] = 0;
    reload_cov();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: field extremes, every action, unused action
    push_item(ACT_PREDICT, 31'd0, 32'd0);
    push_item(ACT_BARO, 31'd0, 32'h7FFFFFFF);
    push_item(ACT_ACCEL, 31'd0, 32'h80000000);
    push_item(ACT_PREDICT, 31'h7FFFFFFF, 32'hFFFFFFFF);
    push_item(2'd3, 31'h7FFFFFFF, 32'h12345678);
    push_item(ACT_BARO, 31'd0, 32'h80000000);
    push_item(ACT_ACCEL, 31'd0, 32'h7FFFFFFF);
    push_item(ACT_PREDICT, 31'd1048576, 32'd0);
    push_item(ACT_BARO, 31'd0, 32'd1048576);
    push_item(ACT_PREDICT, 31'd10486, 32'd0);
    drain();

    // zero measurement noise and covariance: updates before a predict are skipped
    write_reg(REG_RB, 32'd0);
    write_reg(REG_RA, 32'd0);
    write_reg(REG_PINIT, 32'd0);
    repeat (40) @(posedge clk);
    push_item(ACT_BARO, 31'd0, 32'd5000);
    push_item(ACT_ACCEL, 31'd0, 32'hFFF00000);
    push_item(ACT_PREDICT, 31'd0, 32'd0);
    push_item(ACT_BARO, 31'd0, 32'd77);
    drain();

    // all registers at their maximum
    for (int r = 0; r <= REG_PINIT; r++) write_reg(r[2:0], 32'hFFFFFFFF);
    repeat (40) @(posedge clk);
    push_random(60);
    drain();

    // random settings with a long receiver stall
    for (int r = 0; r <= REG_PINIT; r++) write_reg(r[2:0], $urandom);
    repeat (40) @(posedge clk);
    push_random(200);
    hold_cycles = 3000;
    drain();

    // defaults again, but with a small bias noise; realistic flight
    write_reg(REG_QP, 32'd1049);
    write_reg(REG_QV, 32'd10486);
    write_reg(REG_QA, 32'd104858);
    write_reg(REG_QB, 32'd10);
    write_reg(REG_RB, 32'd377487);
    write_reg(REG_RA, 32'd1049);
    write_reg(REG_PINIT, 32'd2097152);
    repeat (40) @(posedge clk);
    push_random(450);
    drain();
    quiet = 1;
    push_random(150);
    drain();
    repeat (400) @(posedge clk);
    if (!failed) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== baro_accel_kalman_filter.f =====
hdl/bakf_pkg.sv
hdl/bakf_regs.sv
hdl/bakf_dp.sv
hdl/bakf_ctrl.sv
hdl/baro_accel_kalman_filter.sv
tb/sv/baro_accel_kalman_filter_test.sv
